### hdl/irle_pkg.sv
// ----------------------------------------------------------------------------
// irle_pkg
// Shared types and constants of the image run-length encoder.
// ----------------------------------------------------------------------------
package irle_pkg;

	localparam int unsigned MAX_RUN_DEF = 255;
	localparam int unsigned CMD_DEPTH   = 4;

	localparam int unsigned DIM_W   = 16;
	localparam int unsigned PIXEL_W = 8;
	localparam int unsigned COUNT_W = 8;
	localparam int unsigned SIZE_W  = 2 * DIM_W;

	// Configuration register indexes
	localparam logic CFG_IMAGE_WIDTH  = 1'b0;
	localparam logic CFG_IMAGE_HEIGHT = 1'b1;

	// One entry of the command queue: everything the back end needs to
	// produce the bytes caused by one pixel.
	typedef struct packed {
		logic               hdr;
		logic [DIM_W-1:0]   width;
		logic [DIM_W-1:0]   height;
		logic               close_v;
		logic [PIXEL_W-1:0] close_color;
		logic [COUNT_W-1:0] close_len;
		logic               flush_v;
		logic [PIXEL_W-1:0] flush_color;
		logic [COUNT_W-1:0] flush_len;
		logic               last;
	} cmd_t;

	// Segments still to be sent for the command at the queue head
	typedef struct packed {
		logic flush;
		logic close;
		logic hdr;
	} seg_mask_t;

endpackage

### hdl/irle_front.sv
// ----------------------------------------------------------------------------
// irle_front
// Accepts pixels, tracks the open run and the frame position, and turns each
// pixel into a command for the byte sequencer.
// ----------------------------------------------------------------------------
module irle_front import irle_pkg::*; #(
	parameter int unsigned MAX_RUN = MAX_RUN_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [DIM_W-1:0]   cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [PIXEL_W-1:0] pixel_color,
	input  logic               cmd_ready,
	output logic               cmd_valid,
	output cmd_t               cmd
);

	localparam logic [COUNT_W-1:0] MAX_RUN_C = COUNT_W'(MAX_RUN);

	logic [DIM_W-1:0]   width_q;
	logic [DIM_W-1:0]   height_q;
	logic [SIZE_W-1:0]  size_q;
	logic [PIXEL_W-1:0] run_color_q;
	logic [COUNT_W-1:0] run_len_q;
	logic [SIZE_W-1:0]  pix_idx_q;

	logic               accept;
	logic               hdr;
	logic               close;
	logic               last;
	logic               flush;
	logic [COUNT_W-1:0] base_len;
	logic [COUNT_W-1:0] new_len;
	logic [PIXEL_W-1:0] new_color;
	logic [DIM_W-1:0]   mul_a;
	logic [DIM_W-1:0]   mul_b;

	// The frame size follows the register being written, so it is valid at
	// the same edge as the register itself.
	always_comb begin
		if (cfg_index == CFG_IMAGE_WIDTH) begin
			mul_a = cfg_data;
			mul_b = height_q;
		end else begin
			mul_a = width_q;
			mul_b = cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= DIM_W'(1);
			height_q <= DIM_W'(1);
			size_q   <= SIZE_W'(1);
		end else if (cfg_we) begin
			size_q <= SIZE_W'(mul_a) * SIZE_W'(mul_b);
			if (cfg_index == CFG_IMAGE_WIDTH) begin
				width_q <= cfg_data;
			end else begin
				height_q <= cfg_data;
			end
		end
	end

	always_comb begin
		hdr       = (pix_idx_q == '0);
		close     = (run_len_q != '0) && (run_color_q != pixel_color);
		base_len  = close ? '0 : run_len_q;
		new_color = (base_len == '0) ? pixel_color : run_color_q;
		new_len   = base_len + COUNT_W'(1);
		last      = ({1'b0, pix_idx_q} + (SIZE_W+1)'(1)) >= {1'b0, size_q};
		flush     = (new_len >= MAX_RUN_C) || last;

		cmd.hdr         = hdr;
		cmd.width       = width_q;
		cmd.height      = height_q;
		cmd.close_v     = close;
		cmd.close_color = run_color_q;
		cmd.close_len   = run_len_q;
		cmd.flush_v     = flush;
		cmd.flush_color = new_color;
		cmd.flush_len   = new_len;
		cmd.last        = last;
	end

	// A pixel that only extends the open run pushes no command, but every pixel waits for queue space.
	assign in_ready  = cmd_ready;
	assign accept    = in_valid && in_ready;
	assign cmd_valid = accept && (hdr || close || flush);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_color_q <= '0;
			run_len_q   <= '0;
			pix_idx_q   <= '0;
		end else if (accept) begin
			run_color_q <= new_color;
			run_len_q   <= flush ? '0 : new_len;
			pix_idx_q   <= last ? '0 : pix_idx_q + SIZE_W'(1);
		end
	end

endmodule

### hdl/irle_queue.sv
// ----------------------------------------------------------------------------
// irle_queue
// Short command queue between the pixel front end and the byte sequencer.
// ----------------------------------------------------------------------------
module irle_queue import irle_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	output logic not_full,
	input  logic pop,
	output logic not_empty,
	output cmd_t head
);

	localparam int unsigned PTR_W = $clog2(CMD_DEPTH);
	localparam int unsigned CNT_W = $clog2(CMD_DEPTH + 1);

	cmd_t             mem_q [CMD_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign not_full  = (count_q != CNT_W'(CMD_DEPTH));
	assign not_empty = (count_q != '0);
	assign head      = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(CMD_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(CMD_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + CNT_W'(1);
				2'b01:   count_q <= count_q - CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

### hdl/irle_back.sv
// ----------------------------------------------------------------------------
// irle_back
// Byte sequencer: walks the header, closed-run and flushed-run segments of
// the command at the queue head and loads one byte per cycle into the
// output register while a command waits and the register is empty or being read.
// ----------------------------------------------------------------------------
module irle_back import irle_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_avail,
	input  cmd_t               head,
	output logic               cmd_pop,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [PIXEL_W-1:0] out_byte,
	output logic               burst_last,
	output logic               frame_end
);

	logic               busy_q;
	seg_mask_t          pend_q;
	logic [2:0]         cnt_q;
	logic               out_valid_q;
	logic [PIXEL_W-1:0] out_byte_q;
	logic               burst_last_q;
	logic               frame_end_q;

	seg_mask_t          head_pend;
	seg_mask_t          cur_pend;
	seg_mask_t          next_pend;
	logic [2:0]         cur_cnt;
	logic               emit;
	logic               seg_end;
	logic               done;
	logic [PIXEL_W-1:0] byte_d;

	always_comb begin
		head_pend.flush = head.flush_v;
		head_pend.close = head.close_v;
		head_pend.hdr   = head.hdr;
		cur_pend  = busy_q ? pend_q : head_pend;
		cur_cnt   = busy_q ? cnt_q : '0;
		emit      = cmd_avail && (!out_valid_q || out_ready);
		next_pend = cur_pend;
		byte_d    = '0;
		seg_end   = 1'b0;
		if (cur_pend.hdr) begin
			// Width then height, each as 32 bits with the low byte first
			case (cur_cnt)
				3'd0:    byte_d = head.width[7:0];
				3'd1:    byte_d = head.width[15:8];
				3'd4:    byte_d = head.height[7:0];
				3'd5:    byte_d = head.height[15:8];
				default: byte_d = '0;
			endcase
			seg_end = (cur_cnt == 3'd7);
			if (seg_end) begin
				next_pend.hdr = 1'b0;
			end
		end else if (cur_pend.close) begin
			byte_d  = cur_cnt[0] ? head.close_len : head.close_color;
			seg_end = cur_cnt[0];
			if (seg_end) begin
				next_pend.close = 1'b0;
			end
		end else begin
			byte_d  = cur_cnt[0] ? head.flush_len : head.flush_color;
			seg_end = cur_cnt[0];
			if (seg_end) begin
				next_pend.flush = 1'b0;
			end
		end
		done    = (next_pend == '0);
		cmd_pop = emit && done;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			pend_q      <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				out_valid_q <= 1'b1;
				busy_q      <= !done;
				pend_q      <= next_pend;
				cnt_q       <= seg_end ? '0 : cur_cnt + 3'd1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_byte_q   <= byte_d;
			burst_last_q <= done;
			frame_end_q  <= done && head.last;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_byte   = out_byte_q;
	assign burst_last = burst_last_q;
	assign frame_end  = frame_end_q;

endmodule

### hdl/image_rle_encoder.sv
// ----------------------------------------------------------------------------
// image_rle_encoder
// Byte-pair run-length encoder for an 8-bit image stream.
// ----------------------------------------------------------------------------
// Pixels enter in raster order on the pixel channel (in_valid/in_ready,
// pixel_color) and the encoded byte stream leaves on the output channel
// (out_valid/out_ready, out_byte, burst_last, frame_end). The first pixel
// of a frame produces an 8-byte header (width, height, 32 bits each, low
// byte first); closed runs produce a colour byte and a count byte.
// burst_last marks the final byte caused by a pixel, frame_end the final
// byte of the frame. A pixel that only extends the open run causes nothing.
// Image width and height are written through cfg_we/cfg_index/cfg_data.
// The first byte of a transaction passes through the command queue and
// the output register. The front end takes one pixel per cycle while its
// command queue has room; the output register sends one byte per cycle
// while out_ready is high, so the pixel rate is set by the bytes per pixel:
// two when every pixel closes a run, up to ten for the first of a frame.
// When the receiver stalls, the output register holds its byte and the
// queue absorbs up to four commands before in_ready falls.
// Reset clears the run, the frame position and the queue, and sets width
// and height to 1.
// ----------------------------------------------------------------------------
module image_rle_encoder import irle_pkg::*; #(
	parameter int unsigned MAX_RUN = MAX_RUN_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [DIM_W-1:0]   cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [PIXEL_W-1:0] pixel_color,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [PIXEL_W-1:0] out_byte,
	output logic               burst_last,
	output logic               frame_end
);

	cmd_t push_cmd;
	cmd_t head;
	logic push;
	logic not_full;
	logic not_empty;
	logic pop;

	irle_front #(
		.MAX_RUN(MAX_RUN)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.pixel_color(pixel_color),
		.cmd_ready  (not_full),
		.cmd_valid  (push),
		.cmd        (push_cmd)
	);

	irle_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.not_full (not_full),
		.pop      (pop),
		.not_empty(not_empty),
		.head     (head)
	);

	irle_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_avail (not_empty),
		.head      (head),
		.cmd_pop   (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_byte  (out_byte),
		.burst_last(burst_last),
		.frame_end (frame_end)
	);

endmodule

### verif/image_rle_encoder_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// image_rle_encoder_test
// Self-checking testbench for the image run-length encoder.
// ----------------------------------------------------------------------------
// Pixels queued by the stimulus process are offered by a clocked driver. Each
// accepted pixel is run through an encoder model in the bench, which queues
// the stream bytes it should cause. A clocked monitor compares every byte that
// leaves the block with the oldest queued byte. Frame sizes are changed only
// while the block is idle. The run covers headers, run limits, zero and
// maximum dimensions, and mid-frame size changes. Both sides idle at random,
// and the receiver holds off once for long enough to stall the pixel input.
// ----------------------------------------------------------------------------
module image_rle_encoder_test;
	import irle_pkg::*;

	typedef struct packed {
		logic [PIXEL_W-1:0] value;
		logic               burst_last;
		logic               frame_end;
	} stream_byte_t;

	logic               clk         = 1'b0;
	logic               arst_n      = 1'b0;
	logic               cfg_we      = 1'b0;
	logic               cfg_index   = CFG_IMAGE_WIDTH;
	logic [DIM_W-1:0]   cfg_data    = '0;
	logic               in_valid    = 1'b0;
	logic               in_ready;
	logic [PIXEL_W-1:0] pixel_color = '0;
	logic               out_valid;
	logic               out_ready   = 1'b0;
	logic [PIXEL_W-1:0] out_byte;
	logic               burst_last;
	logic               frame_end;

	image_rle_encoder dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.pixel_color (pixel_color),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_byte    (out_byte),
		.burst_last  (burst_last),
		.frame_end   (frame_end)
	);

	// Encoder state as the block should hold it.
	logic [DIM_W-1:0]   img_w   = 16'd1;
	logic [DIM_W-1:0]   img_h   = 16'd1;
	logic [PIXEL_W-1:0] run_col = '0;
	logic [COUNT_W-1:0] run_len = '0;
	logic [SIZE_W-1:0]  pix_idx = '0;

	logic [PIXEL_W-1:0] pixel_q[$];
	stream_byte_t       expected_bytes[$];
	int unsigned        mismatches = 0;
	logic               hold_req   = 1'b0;
	logic               calm       = 1'b0;

	initial begin
		forever #2 clk = ~clk;
	end

	initial begin
		#1600000;
		$display("Test completed with failures");
		$finish;
	end

	task automatic report_mismatch(input string msg);
		mismatches++;
		$display("[%0t] mismatch: %s", $time, msg);
	endtask

	// Works out the bytes caused by one pixel and queues them.
	function automatic void encode_pixel(input logic [PIXEL_W-1:0] px);
		stream_byte_t      burst[$];
		logic [SIZE_W-1:0] frame_size;
		logic              at_end;
		frame_size = SIZE_W'(img_w) * SIZE_W'(img_h);
		if (pix_idx == 0) begin
			for (int k = 0; k < 4; k++)
				burst.push_back('{value: PIXEL_W'(SIZE_W'(img_w) >> (8 * k)),
					burst_last: 1'b0, frame_end: 1'b0});
			for (int k = 0; k < 4; k++)
				burst.push_back('{value: PIXEL_W'(SIZE_W'(img_h) >> (8 * k)),
					burst_last: 1'b0, frame_end: 1'b0});
		end
		if (run_len != 0 && run_col != px) begin
			burst.push_back('{value: run_col, burst_last: 1'b0, frame_end: 1'b0});
			burst.push_back('{value: run_len, burst_last: 1'b0, frame_end: 1'b0});
			run_len = '0;
		end
		if (run_len == 0)
			run_col = px;
		run_len = run_len + 1'b1;
		at_end = (pix_idx >= frame_size) || (pix_idx + 1 >= frame_size);
		if (run_len >= MAX_RUN_DEF || at_end) begin
			burst.push_back('{value: run_col, burst_last: 1'b0, frame_end: 1'b0});
			burst.push_back('{value: run_len, burst_last: 1'b0, frame_end: 1'b0});
			run_len = '0;
		end
		if (at_end) begin
			pix_idx = '0;
			burst[burst.size() - 1].frame_end = 1'b1;
		end else begin
			pix_idx = pix_idx + 1;
		end
		// A pixel that only extends the open run causes nothing.
		if (burst.size() != 0) begin
			burst[burst.size() - 1].burst_last = 1'b1;
			foreach (burst[i])
				expected_bytes.push_back(burst[i]);
		end
	endfunction

	// Pixel driver: offers queued pixels, with random idle bursts.
	int unsigned in_gap = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_gap   <= 0;
		end else begin
			if (in_valid && in_ready)
				encode_pixel(pixel_color);
			if (in_valid && !in_ready) begin
				in_valid <= 1'b1;
			end else if (in_gap != 0) begin
				in_gap   <= in_gap - 1;
				in_valid <= 1'b0;
			end else if (pixel_q.size() != 0 && !calm && $urandom_range(0, 5) == 0) begin
				in_gap   <= $urandom_range(0, 4);
				in_valid <= 1'b0;
			end else if (pixel_q.size() != 0) begin
				in_valid    <= 1'b1;
				pixel_color <= pixel_q.pop_front();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Long receiver hold-off, counted here and obeyed by the monitor.
	int unsigned hold_left = 0;
	logic        hold_taken = 1'b0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left  <= 0;
			hold_taken <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end else if (hold_req && !hold_taken) begin
			hold_taken <= 1'b1;
			hold_left  <= 80;
		end
	end

	// Stream monitor: checks each byte and drives out_ready.
	int unsigned out_stall = 0;

	always @(posedge clk or negedge arst_n) begin : monitor
		stream_byte_t want;
		if (!arst_n) begin
			out_ready  <= 1'b0;
			out_stall  <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_bytes.size() == 0) begin
					report_mismatch($sformatf("unexpected byte %02h", out_byte));
				end else begin
					want = expected_bytes.pop_front();
					if (out_byte !== want.value)
						report_mismatch($sformatf("out_byte %02h, expected %02h",
							out_byte, want.value));
					if (burst_last !== want.burst_last)
						report_mismatch($sformatf("burst_last %b, expected %b on byte %02h",
							burst_last, want.burst_last, want.value));
					if (frame_end !== want.frame_end)
						report_mismatch($sformatf("frame_end %b, expected %b on byte %02h",
							frame_end, want.frame_end, want.value));
				end
			end
			// The long hold-off lets the command queue fill and stall the input.
			if (hold_left != 0) begin
				out_ready <= 1'b0;
			end else if (out_stall != 0) begin
				out_stall <= out_stall - 1;
				out_ready <= 1'b0;
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				out_stall <= $urandom_range(0, 4);
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	task automatic write_reg(input logic idx, input logic [DIM_W-1:0] value);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		if (idx == CFG_IMAGE_WIDTH)
			img_w = value;
		else
			img_h = value;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_frame(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
		write_reg(CFG_IMAGE_WIDTH, w);
		write_reg(CFG_IMAGE_HEIGHT, h);
	endtask

	task automatic push_run(input logic [PIXEL_W-1:0] col, input int unsigned len);
		repeat (len) pixel_q.push_back(col);
	endtask

	// Waits until every pixel is taken and every byte has left, then lets
	// quiet pixels still inside the block settle before the next write.
	task automatic drain_stream();
		while (pixel_q.size() != 0 || in_valid || expected_bytes.size() != 0)
			@(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	initial begin : stimulus
		int unsigned        sent;
		int unsigned        sz;
		int unsigned        n;
		int unsigned        len;
		int unsigned        max_len;
		int unsigned        phase;
		logic [PIXEL_W-1:0] col;
		logic [DIM_W-1:0]   w;
		logic [DIM_W-1:0]   h;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Size after reset is one pixel, so every pixel is a frame.
		push_run(8'h00, 1);
		push_run(8'hFF, 1);
		drain_stream();
		// A zero dimension also makes every pixel a whole frame.
		set_frame(16'd0, 16'd1);
		push_run(8'h5A, 1);
		drain_stream();
		set_frame(16'd1, 16'd0);
		push_run(8'hC3, 1);
		drain_stream();
		set_frame(16'hFFFF, 16'hFFFF);
		push_run(8'h03, 3);
		push_run(8'h07, 2);
		push_run(8'hA5, 1);
		drain_stream();
		// Shrinking the frame mid-way: the next pixel is already past the end.
		set_frame(16'd2, 16'd2);
		push_run(8'hA5, 1);
		push_run(8'h01, 2);
		push_run(8'h02, 2);
		drain_stream();
		set_frame(16'd3, 16'd1);
		push_run(8'h09, 3);
		push_run(8'h04, 1);
		push_run(8'h05, 1);
		push_run(8'h06, 1);
		drain_stream();

		sent  = 0;
		phase = 0;
		while (sent < 410) begin
			case ($urandom_range(0, 7))
				0: begin
					w = $urandom_range(0, 1) ? 16'hFFFF : 16'd0;
					h = DIM_W'($urandom_range(1, 4));
				end
				1: begin
					w = DIM_W'($urandom_range(1, 4));
					h = $urandom_range(0, 1) ? 16'hFFFF : 16'd0;
				end
				default: begin
					w = DIM_W'($urandom_range(1, 6));
					h = DIM_W'($urandom_range(1, 6));
				end
			endcase
			if (phase == 2) begin
				w = 16'hFFFF;
				h = 16'd1;
			end
			if (sent >= 330)
				calm = 1'b1;
			if (phase == 1)
				hold_req = 1'b1;
			set_frame(w, h);
			sz = 32'(w) * 32'(h);
			if (sz == 0 || sz > 36)
				n = $urandom_range(8, 30);
			else
				n = sz * $urandom_range(1, 3)
					+ (($urandom_range(0, 3) == 0) ? $urandom_range(1, sz) : 0);
			// Under the long hold-off runs are pushed one pixel at a time, so most pixels close a run.
			max_len = 6;
			if (phase == 1) begin
				n       = 40;
				max_len = 1;
			end
			if (phase == 2) begin
				len = $urandom_range(255, 262);
				push_run(PIXEL_W'($urandom_range(0, 255)), len);
				sent += len;
			end
			if (sent + n > 410)
				n = (sent < 410) ? 410 - sent : 0;
			while (n > 0) begin
				len = $urandom_range(1, max_len);
				if (len > n)
					len = n;
				case ($urandom_range(0, 3))
					0:       col = 8'h00;
					1:       col = 8'hFF;
					default: col = PIXEL_W'($urandom_range(0, 255));
				endcase
				push_run(col, len);
				n    -= len;
				sent += len;
			end
			drain_stream();
			phase++;
		end

		if (mismatches == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

### image_rle_encoder.f
hdl/irle_pkg.sv
hdl/irle_front.sv
hdl/irle_queue.sv
hdl/irle_back.sv
hdl/image_rle_encoder.sv
verif/image_rle_encoder_test.sv
